FILE: hw/rtl/berm_pkg.sv
// Package for the bit error rate meter: payload structs, job and status types,
// register indexes and the fixed-point constants of the log10 datapath.
// No dependencies; every other file of the block imports it.
package berm_pkg;

    // Counter and number formats.
    localparam int BYTE_COUNT_BITS = 40;
    localparam int ERR_BITS        = 48;
    localparam int FRAC_BITS       = 10;
    localparam int LOG_W           = FRAC_BITS + 5;

    // log2 unit: 6 bits of exponent, 24 fraction bits, 64-bit normalising window.
    localparam int LOG2_FRAC  = 24;
    localparam int LOG2_EXP_W = 6;
    localparam int LOG2_W     = LOG2_EXP_W + LOG2_FRAC;
    localparam int NORM_W     = 64;
    localparam int MANT_W     = 32;
    localparam int NORM_STEPS = 6;
    localparam int STEP_W     = 5;

    // log2 difference, log10(2) scaling and rounding.
    localparam int                D_W        = 32;
    localparam int                L10_W      = 29;
    localparam logic [L10_W-1:0]  L10_Q30    = 29'd323228497;
    localparam int                MAG_W      = D_W - 1 + L10_W;
    localparam int                RND_SHIFT  = LOG2_FRAC + 30 - FRAC_BITS;
    localparam int                Q_W        = MAG_W + 1 - RND_SHIFT;
    localparam logic [D_W-1:0]    LOG2_THREE = D_W'(3) << LOG2_FRAC;
    localparam logic [MAG_W:0]    ROUND_HALF = (MAG_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [Q_W-1:0]    Q_MAX      = Q_W'(16) << FRAC_BITS;
    localparam logic [LOG_W-1:0]  MIN_CODE   = LOG_W'(1) << (LOG_W - 1);

    // Configuration port.
    localparam int                  CFG_IDX_W      = 2;
    localparam int                  CFG_DATA_W     = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ERRORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BER_FLOOR  = 2'd2;

    // Report kinds.
    localparam logic [1:0] KIND_STREAM = 2'd0;
    localparam logic [1:0] KIND_MIN    = 2'd1;
    localparam logic [1:0] KIND_FLOOR  = 2'd2;

    // Job queue depth.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] ref_byte;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [LOG_W-1:0] log_ber;
        logic [1:0]              report_kind;
    } t_out_item;

    typedef struct packed {
        logic                    one_shot;
        logic [31:0]             min_errors;
        logic signed [LOG_W-1:0] ber_floor;
    } t_cfg;

    // One counted byte handed from the front to the back.
    typedef struct packed {
        logic [ERR_BITS-1:0]        err_total;
        logic [BYTE_COUNT_BITS-1:0] byte_total;
        logic                       one_shot;
        logic                       min_hit;
    } t_job;

    typedef struct packed {
        logic idle;
        logic run_done;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOG,
        BK_MUL,
        BK_RND
    } t_back_state;

endpackage

FILE: hw/rtl/berm_queue.sv
// Short job queue between the counting front and the log10 back end.
// Depends on berm_pkg for the job type and depth.
module berm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  berm_pkg::t_job i_data,
    input  logic          i_pop,
    output berm_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);
    import berm_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/berm_front.sv
// Front end: accepts byte pairs, counts bit errors and bytes with saturation,
// and queues one job per counted byte. Depends on berm_pkg.
module berm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  berm_pkg::t_cfg      i_cfg,
    input  berm_pkg::t_back_stat i_stat,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  berm_pkg::t_in_item  i_in_data,
    input  logic                i_q_full,
    input  logic                i_q_empty,
    output logic                o_push,
    output berm_pkg::t_job      o_job
);
    import berm_pkg::*;

    logic [ERR_BITS-1:0]        r_err;
    logic [BYTE_COUNT_BITS-1:0] r_bytes;
    logic [ERR_BITS-1:0]        n_err;
    logic [BYTE_COUNT_BITS-1:0] n_bytes;
    logic [7:0]                 w_diff;
    logic [3:0]                 w_bits;
    logic [ERR_BITS:0]          w_sum;
    logic                       w_accept;
    logic                       w_drop;

    // In test mode the back end must finish each byte first, as it may end the run.
    assign o_in_ready = !i_q_full && (!i_cfg.one_shot || (i_stat.idle && i_q_empty));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_drop     = i_cfg.one_shot && i_stat.run_done;
    assign o_push     = w_accept && !w_drop;

    // Popcount of the differing bits.
    always_comb begin
        w_diff = i_in_data.ref_byte ^ i_in_data.rx_byte;
        w_bits = '0;
        for (int i = 0; i < 8; i++) begin
            w_bits = w_bits + 4'(w_diff[i]);
        end
    end

    // Saturating counters.
    always_comb begin
        w_sum   = {1'b0, r_err} + (ERR_BITS + 1)'(w_bits);
        n_err   = w_sum[ERR_BITS] ? {ERR_BITS{1'b1}} : w_sum[ERR_BITS-1:0];
        n_bytes = (&r_bytes) ? r_bytes : r_bytes + 1'b1;
    end

    always_comb begin
        o_job.err_total  = n_err;
        o_job.byte_total = n_bytes;
        o_job.one_shot   = i_cfg.one_shot;
        o_job.min_hit    = (n_err >= {{(ERR_BITS - 32){1'b0}}, i_cfg.min_errors});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_bytes <= '0;
        end else if (o_push) begin
            r_err   <= n_err;
            r_bytes <= n_bytes;
        end
    end

endmodule

FILE: hw/rtl/berm_log2.sv
// Iterative fixed-point log2 unit: a six-step binary leading-one search, then
// 24 squarings of the Q1.31 mantissa, one per cycle. Depends on berm_pkg.
module berm_log2 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [berm_pkg::NORM_W-1:0] i_x,
    output logic                       o_done,
    output logic [berm_pkg::LOG2_W-1:0] o_log2
);
    import berm_pkg::*;

    logic                    r_busy;
    logic                    r_sqr;
    logic                    r_done;
    logic [STEP_W-1:0]       r_step;
    logic [NORM_W-1:0]       r_w;
    logic [LOG2_EXP_W-1:0]   r_lz;
    logic [MANT_W-1:0]       r_m;
    logic [LOG2_FRAC-1:0]    r_frac;
    logic [LOG2_EXP_W:0]     w_shamt;
    logic [NORM_W-1:0]       w_mask;
    logic [NORM_W-1:0]       w_shifted;
    logic                    w_top_zero;
    logic [2*MANT_W-1:0]     w_sq;
    logic [MANT_W:0]         w_t;

    // Normalising step: shift by 32, 16, ... 1 when that many top bits are clear.
    always_comb begin
        w_shamt    = (LOG2_EXP_W + 1)'(MANT_W) >> r_step;
        w_mask     = ~({NORM_W{1'b1}} >> w_shamt);
        w_top_zero = ((r_w & w_mask) == '0);
        w_shifted  = r_w << w_shamt;
    end

    // Squaring step.
    always_comb begin
        w_sq = r_m * r_m;
        w_t  = w_sq[2*MANT_W-1:MANT_W-1];
    end

    assign o_done = r_done;
    assign o_log2 = {LOG2_EXP_W'(NORM_W - 1) - r_lz, r_frac};

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sqr  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_sqr  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            if (!r_sqr && r_step == STEP_W'(NORM_STEPS - 1)) begin
                r_sqr  <= 1'b1;
                r_step <= '0;
            end else if (r_sqr && r_step == STEP_W'(LOG2_FRAC - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w    <= i_x;
            r_lz   <= '0;
            r_frac <= '0;
        end else if (r_busy && !r_sqr) begin
            if (w_top_zero) begin
                r_w  <= w_shifted;
                r_lz <= r_lz + w_shamt[LOG2_EXP_W-1:0];
            end
            if (r_step == STEP_W'(NORM_STEPS - 1)) begin
                r_m <= w_top_zero ? w_shifted[NORM_W-1 -: MANT_W] : r_w[NORM_W-1 -: MANT_W];
            end
        end else if (r_busy && r_sqr) begin
            if (w_t[MANT_W]) begin
                r_m    <= w_t[MANT_W:1];
                r_frac <= {r_frac[LOG2_FRAC-2:0], 1'b1};
            end else begin
                r_m    <= w_t[MANT_W-1:0];
                r_frac <= {r_frac[LOG2_FRAC-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: hw/rtl/berm_back.sv
// Back end: takes jobs from the queue, forms log10(errors / (8 * bytes)) with
// two log2 units, decides the report and drives the output register.
// Depends on berm_pkg and berm_log2.
module berm_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  berm_pkg::t_job         i_job,
    output logic                   o_pop,
    input  logic signed [berm_pkg::LOG_W-1:0] i_floor,
    output berm_pkg::t_back_stat   o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output berm_pkg::t_out_item    o_out_data
);
    import berm_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;
    t_job                    r_job;
    logic                    r_run_done;
    logic                    r_out_vld;
    t_out_item               r_out;
    logic                    r_dpos;
    logic [D_W-2:0]          r_negd;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_start;
    logic                    w_start;
    logic                    w_done_e;
    logic                    w_done_b;
    logic [LOG2_W-1:0]       w_log_e;
    logic [LOG2_W-1:0]       w_log_b;
    logic [D_W-1:0]          w_d;
    logic [D_W-1:0]          w_negd;
    logic [MAG_W-1:0]        w_mag;
    logic [MAG_W:0]          w_rnd;
    logic [Q_W-1:0]          w_q;
    logic [LOG_W-1:0]        w_code;
    logic                    w_emit;
    logic                    w_end;
    t_out_item               w_res;
    logic                    w_out_free;
    logic                    w_load;

    // Two log2 units run side by side: error total and byte total.
    berm_log2 u_log2_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     ({{(NORM_W - ERR_BITS){1'b0}}, r_job.err_total}),
        .o_done  (w_done_e),
        .o_log2  (w_log_e)
    );

    berm_log2 u_log2_byte (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     ({{(NORM_W - BYTE_COUNT_BITS){1'b0}}, r_job.byte_total}),
        .o_done  (w_done_b),
        .o_log2  (w_log_b)
    );

    // log2 difference, less three for the eight bits of a byte.
    always_comb begin
        w_d    = {{(D_W - LOG2_W){1'b0}}, w_log_e} - {{(D_W - LOG2_W){1'b0}}, w_log_b}
                 - LOG2_THREE;
        w_negd = -w_d;
        w_mag  = {{(MAG_W - D_W + 1){1'b0}}, r_negd} * {{(MAG_W - L10_W){1'b0}}, L10_Q30};
    end

    // Rounding, clamping and the report decision.
    always_comb begin
        w_rnd = {1'b0, r_mag} + ROUND_HALF;
        w_q   = w_rnd[MAG_W -: Q_W];
        if (r_job.err_total == '0) begin
            w_code = MIN_CODE;
        end else if (r_dpos) begin
            w_code = '0;
        end else if (w_q > Q_MAX) begin
            w_code = MIN_CODE;
        end else begin
            w_code = -w_q[LOG_W-1:0];
        end

        w_emit = 1'b0;
        w_end  = 1'b0;
        w_res.log_ber     = w_code;
        w_res.report_kind = KIND_STREAM;
        if (!r_job.one_shot) begin
            w_emit = 1'b1;
        end else if (r_job.min_hit) begin
            w_emit = 1'b1;
            w_end  = 1'b1;
            w_res.report_kind = KIND_MIN;
        end else if (r_job.err_total != '0 && $signed(w_code) < i_floor) begin
            w_emit = 1'b1;
            w_end  = 1'b1;
            w_res.log_ber     = i_floor;
            w_res.report_kind = KIND_FLOOR;
        end
    end

    assign w_out_free = !r_out_vld || i_out_ready;

    // Next state and control. The done flags of the previous job are still up
    // while the start pulse is pending, so they are not trusted in that cycle.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_LOG;
                end
            end
            BK_LOG: begin
                if (!r_start && w_done_e && w_done_b) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_RND;
            end
            BK_RND: begin
                if (!w_emit) begin
                    n_state = BK_IDLE;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The units start the cycle after the job is latched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= o_pop;
        end
    end
    assign w_start = r_start;

    // Output register and run status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_run_done <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_load && w_end) begin
                r_run_done <= 1'b1;
            end
        end
    end

    // Job and arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == BK_LOG) begin
            r_dpos <= !w_d[D_W-1];
            r_negd <= w_negd[D_W-2:0];
        end
        if (r_state == BK_MUL) begin
            r_mag <= w_mag;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_stat.idle     = (r_state == BK_IDLE);
    assign o_stat.run_done = r_run_done;
    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;

endmodule

FILE: hw/rtl/bit_error_rate_meter_top.sv
// Top level of the bit error rate meter: configuration registers and the
// front, queue and back instances. Depends on berm_pkg and all berm_ modules.
//
// Use: each input transaction carries a reference byte and a received byte.
// The differing bits are added to a saturating 48-bit error count and a
// saturating 40-bit byte count. The result transaction carries
// log10(errors / (8 * bytes)) in signed Q4.10 and a report kind.
// Streaming mode reports every byte. Test mode reports once, when the error
// count reaches min_errors (kind 1) or the log BER drops below ber_floor
// with errors present (kind 2, carrying ber_floor); later bytes are then
// accepted and discarded until reset.
// From acceptance to a valid result a byte passes the job queue, the job
// register, 6 normalising steps and 24 squarings in the log2 units (one
// 32x32 multiplier each), then difference, scaling and rounding.
// In streaming mode the front goes on taking bytes while the back end works,
// and up to two counted bytes wait in the job queue; in test mode each byte
// is finished before the next is taken.
// Reset clears the counters, the run status and the output register, and
// loads test mode off, min_errors 100, ber_floor -7.0. A stalled result is
// held in the output register; the back end waits behind it and, in streaming
// mode, the queue fills before the input channel deasserts ready.
module bit_error_rate_meter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [berm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [berm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  berm_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output berm_pkg::t_out_item               o_out_data
);
    import berm_pkg::*;

    t_cfg       r_cfg;
    t_back_stat w_stat;
    t_job       w_push_job;
    t_job       w_pop_job;
    logic       w_push;
    logic       w_pop;
    logic       w_q_full;
    logic       w_q_empty;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_shot   <= 1'b0;
            r_cfg.min_errors <= 32'd100;
            r_cfg.ber_floor  <= -LOG_W'(7 << FRAC_BITS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ONE_SHOT:   r_cfg.one_shot   <= i_cfg_data[0];
                REG_MIN_ERRORS: r_cfg.min_errors <= i_cfg_data;
                REG_BER_FLOOR:  r_cfg.ber_floor  <= i_cfg_data[LOG_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    berm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_stat     (w_stat),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .i_q_empty  (w_q_empty),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    berm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    berm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .i_floor     (r_cfg.ber_floor),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
